// ===== design/dmst_pkg.sv =====
// Shared types and constants for the direct-mapped search score table.
package dmst_pkg;

    localparam logic [1:0] CMD_PROBE  = 2'd0;
    localparam logic [1:0] CMD_RECORD = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic [1:0] KIND_EXACT = 2'd1;
    localparam logic [1:0] KIND_UPPER = 2'd2;
    localparam logic [1:0] KIND_LOWER = 2'd3;

    localparam logic signed [31:0] NO_SCORE  = 32'sd65535;
    localparam logic [31:0]        COUNT_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]         command;
        logic [63:0]        position_key;
        logic signed [7:0]  search_depth;
        logic signed [31:0] lower_window;
        logic signed [31:0] upper_window;
        logic signed [31:0] new_score;
        logic [1:0]         new_bound_kind;
        logic signed [31:0] new_move;
        logic               keep_deeper;
    } req_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] score;
        logic signed [31:0] stored_move;
        logic [31:0]        collisions;
    } rsp_t;

    typedef struct packed {
        logic [63:0]        key;
        logic signed [7:0]  depth;
        logic [1:0]         kind;
        logic signed [31:0] score;
        logic signed [31:0] move;
    } entry_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic sweep_step;
        logic finish;
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic req_clear;
        logic sweep_last;
        logic out_free;
    } sts_t;

endpackage

// ===== design/direct_mapped_search_score_table_top.sv =====
// Top level of the direct-mapped search score table.
// Direct-mapped transposition table of TABLE_ENTRIES entries indexed by the low bits of the
// 64-bit position key. A probe, record or unused command is captured together with the
// synchronous read of the entry RAM; the entry is then evaluated, written back and loaded
// into the result register, and the next request can transfer in the cycle after that.
// A clear command sweeps the RAM one entry per cycle and then loads a result. After reset,
// req_stall stays high while the same sweep zeroes the table. A stalled result holds the
// block in evaluation.
module direct_mapped_search_score_table_top #(
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  dmst_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output dmst_pkg::rsp_t rsp
);
    import dmst_pkg::*;

    ctl_t ctl;
    sts_t sts;

    dmst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .ctl       (ctl),
        .sts       (sts)
    );

    dmst_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .ctl       (ctl),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request transfer in two consecutive cycles");

    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.finish |-> (!ctl.capture && !ctl.sweep_step))
        else $error("finish overlaps capture or sweep");

    assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.capture && sts.req_clear) |=> ctl.sweep_step)
        else $error("clear did not start a sweep");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(ctl.finish))
        else $error("result appeared without evaluation");

endmodule

// ===== design/dmst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dmst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/dmst_datapath.sv =====
// Datapath: entry RAM, captured request, probe/record evaluation, counter, result register.
module dmst_datapath #(
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic          clk,
    input  logic          rst_n,
    input  dmst_pkg::req_t req,
    input  dmst_pkg::ctl_t ctl,
    output dmst_pkg::sts_t sts,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output dmst_pkg::rsp_t rsp
);
    import dmst_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    // highest entry index; also the index mask
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    req_t             item_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] sweep_reg;
    logic [IDX_W-1:0] sweep_next;
    logic [IDX_W-1:0] wr_addr;
    entry_t           rd_entry;
    entry_t           wr_entry;
    logic             wr_en;
    logic [31:0]      coll_reg;
    logic [31:0]      coll_next;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    logic             key_match;
    logic             depth_ok;
    logic             keep_old;
    logic             rec_write;

    assign rd_idx = req.position_key[IDX_W-1:0] & LAST_IDX;

    dmst_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_ENTRIES)
    ) u_entries (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_entry),
        .re    (ctl.capture),
        .raddr (rd_idx),
        .rdata (rd_entry)
    );

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            item_reg <= req;
            idx_reg  <= rd_idx;
        end
        if (ctl.finish)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg     <= '0;
            coll_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            sweep_reg     <= sweep_next;
            coll_reg      <= coll_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb
    begin
        sweep_next = sweep_reg;
        if (ctl.sweep_step)
        begin
            sweep_next = (sweep_reg == LAST_IDX) ? '0 : sweep_reg + 1'b1;
        end
    end

    assign key_match = (rd_entry.key == item_reg.position_key);
    assign depth_ok  = (rd_entry.depth >= item_reg.search_depth);
    assign keep_old  = item_reg.keep_deeper && (item_reg.search_depth < rd_entry.depth);
    assign rec_write = ctl.finish && (item_reg.command == CMD_RECORD) && !keep_old;

    always_comb
    begin
        coll_next = coll_reg;
        if (ctl.capture && (req.command == CMD_CLEAR))
        begin
            coll_next = '0;
        end
        else if (ctl.finish && (item_reg.command == CMD_RECORD) && !key_match
                 && (coll_reg != COUNT_MAX))
        begin
            coll_next = coll_reg + 32'd1;
        end
    end

    always_comb
    begin
        if (ctl.sweep_step)
        begin
            wr_en    = 1'b1;
            wr_addr  = sweep_reg;
            wr_entry = '0;
        end
        else
        begin
            wr_en          = rec_write;
            wr_addr        = idx_reg;
            wr_entry.key   = item_reg.position_key;
            wr_entry.depth = item_reg.search_depth;
            wr_entry.kind  = item_reg.new_bound_kind;
            wr_entry.score = item_reg.new_score;
            wr_entry.move  = item_reg.new_move;
        end
    end

    always_comb
    begin
        rsp_next.hit         = 1'b0;
        rsp_next.score       = NO_SCORE;
        rsp_next.stored_move = '0;
        rsp_next.collisions  = coll_next;
        case (item_reg.command)
            CMD_PROBE:
            begin
                rsp_next.stored_move = rd_entry.move;
                if (key_match && depth_ok)
                begin
                    if (rd_entry.kind == KIND_EXACT)
                    begin
                        rsp_next.hit   = 1'b1;
                        rsp_next.score = rd_entry.score;
                    end
                    else if ((rd_entry.kind == KIND_UPPER)
                             && (rd_entry.score < item_reg.lower_window))
                    begin
                        rsp_next.hit   = 1'b1;
                        rsp_next.score = item_reg.lower_window;
                    end
                    else if ((rd_entry.kind == KIND_LOWER)
                             && (rd_entry.score > item_reg.upper_window))
                    begin
                        rsp_next.hit   = 1'b1;
                        rsp_next.score = item_reg.upper_window;
                    end
                end
            end
            CMD_RECORD:
            begin
                rsp_next.stored_move = rd_entry.move;
            end
            default:
            begin
                rsp_next.stored_move = '0;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (ctl.finish)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    assign sts.req_clear  = (req.command == CMD_CLEAR);
    assign sts.sweep_last = (sweep_reg == LAST_IDX);
    assign sts.out_free   = !rsp_valid_reg || !rsp_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== design/dmst_ctrl.sv =====
// Controller: reset clearing pass, request transfer, table sweep and result hand-off.
module dmst_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    output dmst_pkg::ctl_t ctl,
    input  dmst_pkg::sts_t sts
);
    import dmst_pkg::*;

    localparam logic [1:0] ST_INIT  = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EVAL  = 2'd2;
    localparam logic [1:0] ST_SWEEP = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            ST_INIT:
            begin
                ctl.sweep_step = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = sts.req_clear ? ST_SWEEP : ST_EVAL;
                end
            end
            ST_SWEEP:
            begin
                ctl.sweep_step = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                // wait for the result register to drain
                if (sts.out_free)
                begin
                    ctl.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    assign req_stall = (state_reg != ST_IDLE);

endmodule

// ===== bench/tb_direct_mapped_search_score_table_top.sv =====
// Self-checking testbench for the direct-mapped search score table.
`timescale 1ns / 100ps

module tb_direct_mapped_search_score_table_top;
    import dmst_pkg::*;

    localparam int TABLE_ENTRIES = 4096;
    localparam int SLOT_BITS     = $clog2(TABLE_ENTRIES);
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [1:0] KIND_NONE  = 2'd0;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    // shadow copy of the table and the collision counter
    entry_t      shadow_table [TABLE_ENTRIES];
    logic [31:0] shadow_collisions;

    rsp_t        table_replies_due [$];
    logic [63:0] key_pool [16];
    int          mismatch_count;
    int          replies_checked;
    bit          send_gaps_on;
    bit          reply_stalls_on;
    int          stall_run;

    direct_mapped_search_score_table_top #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(11, 40);
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH result %0d: %s", $realtime, replies_checked, what);
        mismatch_count++;
    endtask

    function automatic void wipe_shadow_table();
        foreach (shadow_table[i])
            shadow_table[i] = '0;
        shadow_collisions = '0;
    endfunction

    // Applies one command to the shadow table and returns the reply it must produce.
    function automatic rsp_t apply_table_command(input req_t r);
        rsp_t                 o;
        entry_t               e;
        logic [SLOT_BITS-1:0] slot;
        slot          = r.position_key[SLOT_BITS-1:0];
        e             = shadow_table[slot];
        o.hit         = 1'b0;
        o.score       = NO_SCORE;
        o.stored_move = '0;
        case (r.command)
            CMD_PROBE:
            begin
                o.stored_move = e.move;
                if (e.key == r.position_key && $signed(e.depth) >= $signed(r.search_depth))
                begin
                    if (e.kind == KIND_EXACT)
                    begin
                        o.hit   = 1'b1;
                        o.score = e.score;
                    end
                    else if (e.kind == KIND_UPPER && $signed(e.score) < $signed(r.lower_window))
                    begin
                        o.hit   = 1'b1;
                        o.score = r.lower_window;
                    end
                    else if (e.kind == KIND_LOWER && $signed(e.score) > $signed(r.upper_window))
                    begin
                        o.hit   = 1'b1;
                        o.score = r.upper_window;
                    end
                end
            end
            CMD_RECORD:
            begin
                o.stored_move = e.move;
                if (e.key != r.position_key && shadow_collisions != COUNT_MAX)
                    shadow_collisions++;
                // depth-preferred replacement skips shallower records
                if (!(r.keep_deeper && $signed(r.search_depth) < $signed(e.depth)))
                begin
                    e.key   = r.position_key;
                    e.depth = r.search_depth;
                    e.kind  = r.new_bound_kind;
                    e.score = r.new_score;
                    e.move  = r.new_move;
                    shadow_table[slot] = e;
                end
            end
            CMD_CLEAR:
                wipe_shadow_table();
            default: ;
        endcase
        o.collisions = shadow_collisions;
        return o;
    endfunction

    function automatic req_t table_request(input logic [1:0] command,
                                           input logic [63:0] key,
                                           input logic signed [7:0] depth,
                                           input logic signed [31:0] alpha,
                                           input logic signed [31:0] beta,
                                           input logic signed [31:0] score,
                                           input logic [1:0] kind,
                                           input logic signed [31:0] move,
                                           input logic keep);
        req_t r;
        r.command        = command;
        r.position_key   = key;
        r.search_depth   = depth;
        r.lower_window   = alpha;
        r.upper_window   = beta;
        r.new_score      = score;
        r.new_bound_kind = kind;
        r.new_move       = move;
        r.keep_deeper    = keep;
        return r;
    endfunction

    // Entered right after a posedge; returns at the posedge of the transfer.
    task automatic send_request(input req_t item);
        int gap;
        gap = send_gaps_on ? pick_gap() : 0;
        repeat (gap)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        table_replies_due.push_back(apply_table_command(item));
    endtask

    task automatic wait_for_replies();
        @(negedge clk);
        req_valid <= 1'b0;
        while (table_replies_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2, 3:    return $urandom;
            default: return 32'($urandom_range(0, 600)) - 32'd300;
        endcase
    endfunction

    function automatic logic signed [7:0] pick_depth();
        if ($urandom_range(0, 4) == 0)
            return 8'($urandom);
        return 8'($urandom_range(0, 11)) - 8'd3;
    endfunction

    // Mostly probes and records on a small key pool so entries get revisited.
    function automatic req_t random_request();
        req_t r;
        int   c;
        r = table_request(CMD_PROBE, key_pool[$urandom_range(0, 15)], pick_depth(),
                          pick_value(), pick_value(), pick_value(),
                          2'($urandom_range(1, 3)), $urandom, 1'($urandom));
        c = $urandom_range(0, 299);
        if (c < 140)
            r.command = CMD_PROBE;
        else if (c < 288)
            r.command = CMD_RECORD;
        else if (c < 290)
            r.command = CMD_CLEAR;
        else
            r.command = CMD_UNUSED;
        if ($urandom_range(0, 9) == 0)
            r.position_key = {$urandom, $urandom};
        if ($urandom_range(0, 15) == 0)
            r.new_bound_kind = KIND_NONE;
        return r;
    endfunction

    task automatic test_empty_table();
        send_request(table_request(CMD_PROBE, 64'd0, 8'sd0, 32'sd0, 32'sd0,
                                   32'sd0, KIND_EXACT, 32'sd0, 1'b0));
        send_request(table_request(CMD_PROBE, '1, -8'sd128, 32'sh7FFF_FFFF, 32'sh8000_0000,
                                   32'sd0, KIND_EXACT, 32'sd0, 1'b0));
    endtask

    task automatic test_exact_entries();
        send_request(table_request(CMD_RECORD, 64'hA5A5_0000_1234_5123, 8'sd5, 32'sd0,
                                   32'sd0, -32'sd7, KIND_EXACT, 32'sh8000_0000, 1'b0));
        send_request(table_request(CMD_PROBE, 64'hA5A5_0000_1234_5123, 8'sd5, 32'sd0,
                                   32'sd0, 32'sd0, KIND_NONE, 32'sd0, 1'b0));
        // asked deeper than stored
        send_request(table_request(CMD_PROBE, 64'hA5A5_0000_1234_5123, 8'sd6, 32'sd0,
                                   32'sd0, 32'sd0, KIND_NONE, 32'sd0, 1'b0));
        // same slot, other key: no hit but the move comes back
        send_request(table_request(CMD_PROBE, 64'h5A5A_FFFF_EDCB_A123, -8'sd128, 32'sd0,
                                   32'sd0, 32'sd0, KIND_NONE, 32'sd0, 1'b0));
    endtask

    task automatic test_bound_entries();
        send_request(table_request(CMD_RECORD, 64'h0000_0001_0000_0777, 8'sd3, 32'sd0,
                                   32'sd0, 32'sd100, KIND_UPPER, 32'sh7FFF_FFFF, 1'b0));
        send_request(table_request(CMD_PROBE, 64'h0000_0001_0000_0777, 8'sd3, 32'sd200,
                                   32'sh7FFF_FFFF, 32'sd0, KIND_NONE, 32'sd0, 1'b0));
        send_request(table_request(CMD_PROBE, 64'h0000_0001_0000_0777, -8'sd1, 32'sd100,
                                   32'sd0, 32'sd0, KIND_NONE, 32'sd0, 1'b0));
        send_request(table_request(CMD_RECORD, 64'hFFFF_0000_0000_0FFF, 8'sd127, 32'sd0,
                                   32'sd0, -32'sd100, KIND_LOWER, -32'sd1, 1'b1));
        send_request(table_request(CMD_PROBE, 64'hFFFF_0000_0000_0FFF, 8'sd127,
                                   32'sh8000_0000, -32'sd200, 32'sd0, KIND_NONE, 32'sd0, 1'b0));
        send_request(table_request(CMD_PROBE, 64'hFFFF_0000_0000_0FFF, 8'sd0, 32'sd0,
                                   -32'sd100, 32'sd0, KIND_NONE, 32'sd0, 1'b0));
    endtask

    task automatic test_replacement();
        // an exact score equal to the no-score code still reports a hit
        send_request(table_request(CMD_RECORD, 64'h1111_2222_3333_4000, 8'sd127, 32'sd0,
                                   32'sd0, NO_SCORE, KIND_EXACT, 32'sd9, 1'b0));
        send_request(table_request(CMD_PROBE, 64'h1111_2222_3333_4000, 8'sd127, 32'sd0,
                                   32'sd0, 32'sd0, KIND_NONE, 32'sd0, 1'b0));
        // equal depth with keep_deeper still writes; kind none never hits
        send_request(table_request(CMD_RECORD, 64'h1111_2222_3333_4000, 8'sd127, 32'sd0,
                                   32'sd0, 32'sd5, KIND_NONE, 32'sd10, 1'b1));
        send_request(table_request(CMD_PROBE, 64'h1111_2222_3333_4000, -8'sd128, 32'sd0,
                                   32'sd0, 32'sd0, KIND_NONE, 32'sd0, 1'b0));
        // shallower record is dropped, then forced in
        send_request(table_request(CMD_RECORD, 64'hA5A5_0000_1234_5123, 8'sd2, 32'sd0,
                                   32'sd0, 32'sd44, KIND_EXACT, 32'sd11, 1'b1));
        send_request(table_request(CMD_PROBE, 64'hA5A5_0000_1234_5123, 8'sd2, 32'sd0,
                                   32'sd0, 32'sd0, KIND_NONE, 32'sd0, 1'b0));
        send_request(table_request(CMD_RECORD, 64'hA5A5_0000_1234_5123, 8'sd2, 32'sd0,
                                   32'sd0, 32'sd44, KIND_EXACT, 32'sd11, 1'b0));
        send_request(table_request(CMD_PROBE, 64'hA5A5_0000_1234_5123, 8'sd2, 32'sd0,
                                   32'sd0, 32'sd0, KIND_NONE, 32'sd0, 1'b0));
    endtask

    task automatic test_collisions_and_clear();
        send_request(table_request(CMD_RECORD, 64'h0BAD_0000_0000_0123, -8'sd128, 32'sd0,
                                   32'sd0, 32'sd1, KIND_LOWER, 32'sd12, 1'b1));
        send_request(table_request(CMD_UNUSED, 64'h0BAD_0000_0000_0123, 8'sd0, 32'sd0,
                                   32'sd0, 32'sd0, KIND_EXACT, 32'sd0, 1'b0));
        send_request(table_request(CMD_CLEAR, 64'd0, 8'sd0, 32'sd0, 32'sd0,
                                   32'sd0, KIND_NONE, 32'sd0, 1'b0));
        send_request(table_request(CMD_PROBE, 64'hA5A5_0000_1234_5123, -8'sd128, 32'sd0,
                                   32'sd0, 32'sd0, KIND_NONE, 32'sd0, 1'b0));
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count)
            send_request(random_request());
    endtask

    task automatic test_back_to_back(input int count);
        wait_for_replies();
        send_gaps_on    = 1'b0;
        reply_stalls_on = 1'b0;
        repeat (count)
            send_request(random_request());
        send_gaps_on    = 1'b1;
        reply_stalls_on = 1'b1;
    endtask

    // before every 40th request the sender holds off until the table has answered everything
    task automatic test_pause_for_results(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 39)
                wait_for_replies();
            send_request(random_request());
        end
    endtask

    always @(negedge clk)
    begin
        if (stall_run > 0)
        begin
            rsp_stall <= 1'b1;
            stall_run--;
        end
        else
        begin
            rsp_stall <= 1'b0;
            if (reply_stalls_on && $urandom_range(0, 4) == 0)
                stall_run = pick_gap();
        end
    end

    always @(posedge clk)
    begin : check_replies
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (table_replies_due.size() == 0)
                report_mismatch("result with no request outstanding");
            else
            begin
                want = table_replies_due.pop_front();
                if (rsp.hit !== want.hit)
                    report_mismatch($sformatf("hit %b, want %b", rsp.hit, want.hit));
                if (rsp.score !== want.score)
                    report_mismatch($sformatf("score %0d, want %0d", rsp.score, want.score));
                if (rsp.stored_move !== want.stored_move)
                    report_mismatch($sformatf("stored_move %0d, want %0d",
                                              rsp.stored_move, want.stored_move));
                if (rsp.collisions !== want.collisions)
                    report_mismatch($sformatf("collisions %0d, want %0d",
                                              rsp.collisions, want.collisions));
            end
            replies_checked++;
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        req_valid       = 1'b0;
        req             = '0;
        rsp_stall       = 1'b0;
        stall_run       = 0;
        mismatch_count  = 0;
        replies_checked = 0;
        send_gaps_on    = 1'b1;
        reply_stalls_on = 1'b1;
        wipe_shadow_table();
        foreach (key_pool[i])
            key_pool[i] = {$urandom, $urandom};
        // pool keys 8 to 11 share a slot with keys 0 to 3
        for (int i = 8; i < 12; i++)
            key_pool[i][SLOT_BITS-1:0] = key_pool[i-8][SLOT_BITS-1:0];
        key_pool[12] = '0;
        key_pool[13] = '1;
        repeat (5)
            @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        test_empty_table();
        test_exact_entries();
        test_bound_entries();
        test_replacement();
        test_collisions_and_clear();
        test_random_traffic(1000);
        test_back_to_back(300);
        test_pause_for_results(400);

        wait_for_replies();
        repeat (20)
            @(posedge clk);
        if (mismatch_count == 0 && table_replies_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
